/* rtl/core/stq_pkg.sv */
// Shared types, codes and constants for the sorted timer event queue.
// Used by every module of the block; depends on nothing else.
package stq_pkg;

    // Field widths fixed by the interface.
    localparam int CMD_W    = 2;
    localparam int DELTA_W  = 32;
    localparam int TAG_W    = 16;
    localparam int TIME_W   = 48;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    // Largest tick value; deadlines and the tick counter stop here.
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Default number of table entries and the cap on events fired per tick.
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int FIRE_CNT_W      = $clog2(MAX_RESULTS);

    // Slots in the queue between the front and back ends (a power of two).
    localparam int JOB_SLOTS = 2;
    localparam int JOB_PTR_W = $clog2(JOB_SLOTS);

    // Command codes on the input.
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DROP   = 2'd2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_FIRED  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_IDLE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DROP   = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    // Operation carried from the front end to the back end.
    typedef enum logic [1:0] {
        OP_TICK,
        OP_INSERT,
        OP_DROP
    } t_op;

    // One queued job.
    typedef struct packed {
        t_op                op;
        logic [DELTA_W-1:0] delta;
        logic [TAG_W-1:0]   tag;
    } t_job;

    // Back end sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_FIRE
    } t_state;

    // Per-cycle actions decided by the back end sequencer.
    typedef struct packed {
        logic pop;
        logic do_insert;
        logic do_drop;
        logic do_tick;
        logic do_fire;
        logic load_out;
    } t_back_ctl;

endpackage

/* rtl/core/sorted_timer_event_queue_unit.sv */
// Top level of the sorted timer event queue: front end, job queue and back end.
// Depends on stq_pkg, stq_front and stq_back.
//
// The block keeps a 48-bit tick counter and a table of up to QUEUE_DEPTH timer
// events sorted by deadline. An insert beat schedules a tag at now plus delta
// (saturating) behind any equal deadline, a drop beat removes the first entry
// with the tag, and a tick beat advances the counter and then fires every due
// event, earliest first and at most sixteen per tick, or gives one idle result.
// A command code of three is accepted and produces nothing. The front end
// holds two jobs, so input beats are taken while the back end works or while
// a result waits on the output. In the back end an insert or a drop gives one
// result; a tick first advances the counter and then gives one result per fired
// event (one for an idle tick), all through the single-ported compare-and-shift
// table that handles one operation per cycle while the output register is free.
// The last result of every input beat has o_last set.
module sorted_timer_event_queue_unit
    import stq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [DELTA_W-1:0]  i_delta,
    input  logic [TAG_W-1:0]    i_event_tag,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [KIND_W-1:0]   o_kind,
    output logic [STATUS_W-1:0] o_status,
    output logic [TAG_W-1:0]    o_fired_tag,
    output logic [TIME_W-1:0]   o_deadline,
    output logic [TIME_W-1:0]   o_now,
    output logic                o_last
);

    logic w_job_valid;
    t_job w_job;
    logic w_job_pop;

    // Input decode and job queue.
    stq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_delta     (i_delta),
        .i_event_tag (i_event_tag),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_pop   (w_job_pop)
    );

    // Sorted table, tick counter and result output.
    stq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_pop   (w_job_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_kind      (o_kind),
        .o_status    (o_status),
        .o_fired_tag (o_fired_tag),
        .o_deadline  (o_deadline),
        .o_now       (o_now),
        .o_last      (o_last)
    );

    // An idle tick is always a single zeroed result.
    a_idle_shape : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_IDLE |->
            o_last && o_fired_tag == '0 && o_deadline == '0)
        else $error("idle result is not a single zeroed beat");

    // A fired event is never ahead of the tick counter.
    a_fire_due : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_FIRED |-> o_deadline <= o_now)
        else $error("event fired before its deadline");

    // Inserts and drops each give exactly one result.
    a_single_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_INSERT || o_kind == KIND_DROP) |-> o_last)
        else $error("insert or drop result not marked last");

    // Status codes only appear on the operations that can raise them.
    a_status_kind : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != STATUS_OK |->
            (o_status == STATUS_FULL && o_kind == KIND_INSERT) ||
            (o_status == STATUS_NOT_FOUND && o_kind == KIND_DROP))
        else $error("status code on the wrong result kind");

endmodule

/* rtl/core/stq_front.sv */
// Front end: accepts input beats, decodes the command and queues the job.
// Depends on stq_pkg.
module stq_front
    import stq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [CMD_W-1:0]   i_command,
    input  logic [DELTA_W-1:0] i_delta,
    input  logic [TAG_W-1:0]   i_event_tag,
    output logic               o_job_valid,
    output t_job               o_job,
    input  logic               i_job_pop
);

    localparam int CNT_W = $clog2(JOB_SLOTS + 1);

    t_job                 r_slot [JOB_SLOTS];
    logic [JOB_PTR_W-1:0] r_wr_ptr;
    logic [JOB_PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0]     r_cnt;

    t_op  w_op;
    logic w_known;
    logic w_push;
    logic w_pop;

    // Decode the command; an unknown code is taken and dropped.
    always_comb begin
        w_op    = OP_TICK;
        w_known = 1'b1;
        case (i_command)
            CMD_TICK:   w_op = OP_TICK;
            CMD_INSERT: w_op = OP_INSERT;
            CMD_DROP:   w_op = OP_DROP;
            default:    w_known = 1'b0;
        endcase
    end

    assign o_in_ready  = (r_cnt != CNT_W'(JOB_SLOTS));
    assign w_push      = i_in_valid && o_in_ready && w_known;
    assign o_job_valid = (r_cnt != '0);
    assign w_pop       = i_job_pop && o_job_valid;
    assign o_job       = r_slot[r_rd_ptr];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= '{op: w_op, delta: i_delta, tag: i_event_tag};
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/stq_back.sv */
// Back end: the sorted compare-and-shift table, the tick counter, the
// sequencer and the output register. Depends on stq_pkg.
module stq_back
    import stq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  t_job                i_job,
    output logic                o_job_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [KIND_W-1:0]   o_kind,
    output logic [STATUS_W-1:0] o_status,
    output logic [TAG_W-1:0]    o_fired_tag,
    output logic [TIME_W-1:0]   o_deadline,
    output logic [TIME_W-1:0]   o_now,
    output logic                o_last
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Table, kept in ascending deadline order below r_count.
    logic [TIME_W-1:0]     r_dl  [QUEUE_DEPTH];
    logic [TAG_W-1:0]      r_tag [QUEUE_DEPTH];
    logic [TIME_W-1:0]     n_dl  [QUEUE_DEPTH];
    logic [TAG_W-1:0]      n_tag [QUEUE_DEPTH];
    logic [CNT_W-1:0]      r_count;
    logic [TIME_W-1:0]     r_now;
    logic [FIRE_CNT_W-1:0] r_fired;
    t_state                r_state;
    t_state                n_state;

    // Output register.
    logic                r_out_valid;
    logic [KIND_W-1:0]   r_kind;
    logic [STATUS_W-1:0] r_status;
    logic [TAG_W-1:0]    r_tag_out;
    logic [TIME_W-1:0]   r_dl_out;
    logic [TIME_W-1:0]   r_now_out;
    logic                r_last;
    logic [KIND_W-1:0]   n_kind;
    logic [STATUS_W-1:0] n_status;
    logic [TAG_W-1:0]    n_tag_out;
    logic [TIME_W-1:0]   n_dl_out;
    logic                n_last;

    t_back_ctl          w_ctl;
    logic               w_out_free;
    logic [TIME_W:0]    w_sum;
    logic [TIME_W-1:0]  w_ins_dl;
    logic [TIME_W-1:0]  w_tick_now;
    logic               w_has_room;
    logic               w_found;
    logic [TIME_W-1:0]  w_drop_dl;
    logic               w_due0;
    logic               w_due1;
    logic               w_fire_last;

    logic [QUEUE_DEPTH-1:0] w_valid;
    logic [QUEUE_DEPTH-1:0] w_le;
    logic [QUEUE_DEPTH-1:0] w_ins_at;
    logic [QUEUE_DEPTH-1:0] w_match;
    logic [QUEUE_DEPTH-1:0] w_past;
    logic [QUEUE_DEPTH-1:0] w_first;
    logic [TIME_W-1:0]      w_up_dl  [QUEUE_DEPTH];
    logic [TAG_W-1:0]       w_up_tag [QUEUE_DEPTH];
    logic [TIME_W-1:0]      w_dn_dl  [QUEUE_DEPTH];
    logic [TAG_W-1:0]       w_dn_tag [QUEUE_DEPTH];

    assign w_out_free = !r_out_valid || i_out_ready;

    // Deadline of an insert, saturating at the largest tick value.
    assign w_sum    = {1'b0, r_now} + (TIME_W + 1)'(i_job.delta);
    assign w_ins_dl = w_sum[TIME_W] ? TIME_MAX : w_sum[TIME_W-1:0];

    // Tick counter advance, saturating.
    assign w_tick_now = (r_now == TIME_MAX) ? TIME_MAX : r_now + 1'b1;

    assign w_has_room = (r_count < CNT_W'(QUEUE_DEPTH));

    // Per-entry compares and the neighbour values each entry may shift in.
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_entry
        assign w_valid[g] = (CNT_W'(g) < r_count);
        assign w_le[g]    = w_valid[g] && (r_dl[g] <= w_ins_dl);
        assign w_match[g] = w_valid[g] && (r_tag[g] == i_job.tag);

        if (g == 0) begin : g_head
            assign w_ins_at[g] = !w_le[g];
            assign w_past[g]   = w_match[g];
            assign w_first[g]  = w_match[g];
            assign w_up_dl[g]  = w_ins_dl;
            assign w_up_tag[g] = i_job.tag;
        end else begin : g_body
            assign w_ins_at[g] = !w_le[g] && w_le[g-1];
            assign w_past[g]   = w_past[g-1] || w_match[g];
            assign w_first[g]  = w_match[g] && !w_past[g-1];
            assign w_up_dl[g]  = r_dl[g-1];
            assign w_up_tag[g] = r_tag[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_dn_dl[g]  = r_dl[g];
            assign w_dn_tag[g] = r_tag[g];
        end else begin : g_inner
            assign w_dn_dl[g]  = r_dl[g+1];
            assign w_dn_tag[g] = r_tag[g+1];
        end

        // Next value: open a gap for an insert, close one for a drop or a fire.
        always_comb begin
            n_dl[g]  = r_dl[g];
            n_tag[g] = r_tag[g];
            if (w_ctl.do_insert && w_has_room && !w_le[g]) begin
                n_dl[g]  = w_ins_at[g] ? w_ins_dl  : w_up_dl[g];
                n_tag[g] = w_ins_at[g] ? i_job.tag : w_up_tag[g];
            end else if ((w_ctl.do_drop && w_past[g]) || w_ctl.do_fire) begin
                n_dl[g]  = w_dn_dl[g];
                n_tag[g] = w_dn_tag[g];
            end
        end
    end

    assign w_found = w_past[QUEUE_DEPTH-1];

    // Deadline of the first entry holding the dropped tag.
    always_comb begin
        w_drop_dl = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (w_first[i]) begin
                w_drop_dl = w_drop_dl | r_dl[i];
            end
        end
    end

    // Head and next-to-head due checks for the firing loop.
    assign w_due0      = w_valid[0] && (r_dl[0] <= r_now);
    assign w_due1      = w_valid[1] && (r_dl[1] <= r_now);
    assign w_fire_last = !w_due1 || (r_fired == FIRE_CNT_W'(MAX_RESULTS - 1));

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid && w_out_free && i_job.op == OP_TICK) begin
                    n_state = ST_FIRE;
                end
            end
            ST_FIRE: begin
                if (w_out_free && (!w_due0 || w_fire_last)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer actions.
    always_comb begin
        w_ctl = '0;
        case (r_state)
            ST_IDLE: begin
                w_ctl.pop       = i_job_valid && w_out_free;
                w_ctl.do_insert = w_ctl.pop && (i_job.op == OP_INSERT);
                w_ctl.do_drop   = w_ctl.pop && (i_job.op == OP_DROP);
                w_ctl.do_tick   = w_ctl.pop && (i_job.op == OP_TICK);
                w_ctl.load_out  = w_ctl.do_insert || w_ctl.do_drop;
            end
            ST_FIRE: begin
                w_ctl.do_fire  = w_out_free && w_due0;
                w_ctl.load_out = w_out_free;
            end
            default: w_ctl = '0;
        endcase
    end

    assign o_job_pop = w_ctl.pop;

    // Result payload for the beat being loaded.
    always_comb begin
        n_kind    = KIND_IDLE;
        n_status  = STATUS_OK;
        n_tag_out = '0;
        n_dl_out  = '0;
        n_last    = 1'b1;
        if (w_ctl.do_insert) begin
            n_kind    = KIND_INSERT;
            n_status  = w_has_room ? STATUS_OK : STATUS_FULL;
            n_tag_out = i_job.tag;
            n_dl_out  = w_ins_dl;
        end else if (w_ctl.do_drop) begin
            n_kind    = KIND_DROP;
            n_status  = w_found ? STATUS_OK : STATUS_NOT_FOUND;
            n_tag_out = i_job.tag;
            n_dl_out  = w_drop_dl;
        end else if (w_ctl.do_fire) begin
            n_kind    = KIND_FIRED;
            n_tag_out = r_tag[0];
            n_dl_out  = r_dl[0];
            n_last    = w_fire_last;
        end
    end

    // Table storage.
    always_ff @(posedge i_clk) begin
        r_dl  <= n_dl;
        r_tag <= n_tag;
    end

    // Control state: fill count, tick counter, fire counter, sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_now   <= '0;
            r_fired <= '0;
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
            if (w_ctl.do_insert && w_has_room) begin
                r_count <= r_count + 1'b1;
            end else if ((w_ctl.do_drop && w_found) || w_ctl.do_fire) begin
                r_count <= r_count - 1'b1;
            end
            if (w_ctl.do_tick) begin
                r_now   <= w_tick_now;
                r_fired <= '0;
            end else if (w_ctl.do_fire) begin
                r_fired <= r_fired + 1'b1;
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_ctl.load_out) begin
            r_kind    <= n_kind;
            r_status  <= n_status;
            r_tag_out <= n_tag_out;
            r_dl_out  <= n_dl_out;
            r_last    <= n_last;
            r_now_out <= r_now;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_status    = r_status;
    assign o_fired_tag = r_tag_out;
    assign o_deadline  = r_dl_out;
    assign o_now       = r_now_out;
    assign o_last      = r_last;

endmodule

/* verif/tb_sorted_timer_event_queue_unit.sv */
// Self-checking testbench for the sorted timer event queue unit.
// Depends on stq_pkg and sorted_timer_event_queue_unit; runs a directed table,
// then random beats.
module tb_sorted_timer_event_queue_unit;
    import stq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = DEF_QUEUE_DEPTH;
    // Command code that the block accepts and ignores.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_PER_PHASE = 110;
    localparam int REPORT_LIMIT = 10;

    // One result beat as seen on the output ports.
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    tag;
        logic [TIME_W-1:0]   deadline;
        logic [TIME_W-1:0]   now;
        logic                last;
    } t_outcome;

    // One row of stimulus; typed rows carry their own expected result.
    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [DELTA_W-1:0] delta;
        logic [TAG_W-1:0]   tag;
        bit                 typed;
        t_outcome           want;
    } t_stim_row;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic [CMD_W-1:0]    i_command   = CMD_TICK;
    logic [DELTA_W-1:0]  i_delta     = '0;
    logic [TAG_W-1:0]    i_event_tag = '0;
    logic                i_out_ready = 1'b1;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [KIND_W-1:0]   o_kind;
    logic [STATUS_W-1:0] o_status;
    logic [TAG_W-1:0]    o_fired_tag;
    logic [TIME_W-1:0]   o_deadline;
    logic [TIME_W-1:0]   o_now;
    logic                o_last;

    sorted_timer_event_queue_unit #(
        .QUEUE_DEPTH(TABLE_DEPTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_delta     (i_delta),
        .i_event_tag (i_event_tag),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_kind      (o_kind),
        .o_status    (o_status),
        .o_fired_tag (o_fired_tag),
        .o_deadline  (o_deadline),
        .o_now       (o_now),
        .o_last      (o_last)
    );

    // Shadow copy of the tick counter and the sorted event table.
    logic [TIME_W-1:0] shadow_now;
    logic [TIME_W-1:0] shadow_deadline [TABLE_DEPTH];
    logic [TAG_W-1:0]  shadow_tag [TABLE_DEPTH];
    int                shadow_count;

    // Results still owed by the block, oldest first.
    t_outcome awaited_results [$];

    int stall_pct;
    int mismatch_count;
    int unexpected_count;
    int beats_sent;
    int fired_count;
    int idle_count;
    int full_count;
    int missing_count;
    int ignored_count;

    function automatic t_outcome make_outcome(logic [KIND_W-1:0] kind,
                                              logic [STATUS_W-1:0] status,
                                              logic [TAG_W-1:0] tag,
                                              logic [TIME_W-1:0] deadline,
                                              logic [TIME_W-1:0] now);
        t_outcome res;
        res.kind     = kind;
        res.status   = status;
        res.tag      = tag;
        res.deadline = deadline;
        res.now      = now;
        res.last     = 1'b1;
        return res;
    endfunction

    function automatic t_stim_row make_row(logic [CMD_W-1:0] cmd, logic [DELTA_W-1:0] delta,
                                           logic [TAG_W-1:0] tag, bit typed, t_outcome want);
        t_stim_row row;
        row.cmd   = cmd;
        row.delta = delta;
        row.tag   = tag;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    // Close the gap left by the entry at pos in the shadow table.
    function automatic void remove_entry(int pos);
        int i;
        for (i = pos; i + 1 < shadow_count; i++) begin
            shadow_deadline[i] = shadow_deadline[i + 1];
            shadow_tag[i]      = shadow_tag[i + 1];
        end
        shadow_count--;
    endfunction

    // Apply one accepted command to the shadow state and queue the results it causes.
    function automatic void apply_command(logic [CMD_W-1:0] cmd, logic [DELTA_W-1:0] delta,
                                          logic [TAG_W-1:0] tag);
        t_outcome          batch [MAX_RESULTS];
        int                n;
        int                pos;
        int                i;
        bit                found;
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] due;
        n = 0;
        case (cmd)
            CMD_TICK: begin
                if (shadow_now != TIME_MAX)
                    shadow_now = shadow_now + 1'b1;
                while (shadow_count > 0 && n < MAX_RESULTS &&
                       shadow_deadline[0] <= shadow_now) begin
                    batch[n] = make_outcome(KIND_FIRED, STATUS_OK, shadow_tag[0],
                                            shadow_deadline[0], shadow_now);
                    remove_entry(0);
                    n++;
                end
                fired_count += n;
                if (n == 0) begin
                    batch[0] = make_outcome(KIND_IDLE, STATUS_OK, '0, '0, shadow_now);
                    n = 1;
                    idle_count++;
                end
            end
            CMD_INSERT: begin
                sum = {1'b0, shadow_now} + (TIME_W + 1)'(delta);
                due = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                if (shadow_count >= TABLE_DEPTH) begin
                    batch[0] = make_outcome(KIND_INSERT, STATUS_FULL, tag, due, shadow_now);
                    full_count++;
                end else begin
                    // A new entry goes behind every entry with an equal deadline.
                    pos = 0;
                    while (pos < shadow_count && shadow_deadline[pos] <= due)
                        pos++;
                    for (i = shadow_count; i > pos; i--) begin
                        shadow_deadline[i] = shadow_deadline[i - 1];
                        shadow_tag[i]      = shadow_tag[i - 1];
                    end
                    shadow_deadline[pos] = due;
                    shadow_tag[pos]      = tag;
                    shadow_count++;
                    batch[0] = make_outcome(KIND_INSERT, STATUS_OK, tag, due, shadow_now);
                end
                n = 1;
            end
            CMD_DROP: begin
                found = 1'b0;
                for (i = 0; i < shadow_count && !found; i++) begin
                    if (shadow_tag[i] == tag) begin
                        batch[0] = make_outcome(KIND_DROP, STATUS_OK, tag, shadow_deadline[i],
                                                shadow_now);
                        remove_entry(i);
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    batch[0] = make_outcome(KIND_DROP, STATUS_NOT_FOUND, tag, '0, shadow_now);
                    missing_count++;
                end
                n = 1;
            end
            default: ignored_count++;
        endcase
        for (i = 0; i < n; i++) begin
            batch[i].last = (i == n - 1);
            awaited_results.push_back(batch[i]);
        end
    endfunction

    // Offer one input beat, with random idle cycles first, and wait until it is taken.
    task automatic send_beat(t_stim_row row, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= row.cmd;
        i_delta     <= row.delta;
        i_event_tag <= row.tag;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        beats_sent++;
        apply_command(row.cmd, row.delta, row.tag);
        // A typed row states its single result outright.
        if (row.typed) begin
            void'(awaited_results.pop_back());
            awaited_results.push_back(row.want);
        end
    endtask

    // Build one random beat; most are well formed, drops mostly aim at pending tags.
    function automatic t_stim_row random_row(bit fill_mode);
        t_stim_row row;
        int        pick;
        int        r;
        pick = $urandom_range(99);
        r = $urandom_range(99);
        if (r < 70)
            row.delta = $urandom_range(12);
        else if (r < 80)
            row.delta = '0;
        else if (r < 88)
            row.delta = {DELTA_W{1'b1}};
        else
            row.delta = $urandom;
        r = $urandom_range(99);
        if (r < 50)
            row.tag = TAG_W'($urandom_range(7));
        else if (r < 60)
            row.tag = {TAG_W{1'b1}};
        else
            row.tag = TAG_W'($urandom);
        if (pick < 4)
            row.cmd = CMD_UNUSED;
        else if (pick < (fill_mode ? 70 : 35))
            row.cmd = CMD_INSERT;
        else if (pick < (fill_mode ? 82 : 60)) begin
            row.cmd = CMD_DROP;
            if (shadow_count > 0 && $urandom_range(99) < 75)
                row.tag = shadow_tag[$urandom_range(shadow_count - 1)];
        end else
            row.cmd = CMD_TICK;
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Output side: take result beats, compare with the oldest awaited result, stall at random.
    initial begin
        t_outcome seen;
        t_outcome want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                seen = {o_kind, o_status, o_fired_tag, o_deadline, o_now, o_last};
                if (awaited_results.size() == 0) begin
                    unexpected_count++;
                    if (unexpected_count + mismatch_count <= REPORT_LIMIT)
                        $display({"Unexpected result beat: kind %0d status %0d tag %h",
                                  " dl %h now %h last %b"},
                                 seen.kind, seen.status, seen.tag, seen.deadline, seen.now,
                                 seen.last);
                end else begin
                    want = awaited_results.pop_front();
                    if (seen !== want) begin
                        mismatch_count++;
                        if (unexpected_count + mismatch_count <= REPORT_LIMIT) begin
                            $display({"Mismatch: expected kind %0d status %0d tag %h",
                                      " dl %h now %h last %b"},
                                     want.kind, want.status, want.tag, want.deadline,
                                     want.now, want.last);
                            $display({"          actual   kind %0d status %0d tag %h",
                                      " dl %h now %h last %b"},
                                     seen.kind, seen.status, seen.tag, seen.deadline,
                                     seen.now, seen.last);
                        end
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Give up after a generous fixed time.
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Reset, directed table, random phases, drain and verdict.
    initial begin
        t_stim_row directed_rows [$];
        t_stim_row row;
        int        phase_send_idle [4];
        int        phase_recv_stall [4];
        int        ph;
        int        done;
        int        i;
        int        leftover;

        shadow_now   = '0;
        shadow_count = 0;
        stall_pct    = 0;
        mismatch_count = 0;
        unexpected_count = 0;
        beats_sent = 0;
        fired_count = 0;
        idle_count = 0;
        full_count = 0;
        missing_count = 0;
        ignored_count = 0;
        phase_send_idle  = '{0, 74, 0, 36};
        phase_recv_stall = '{0, 0, 74, 36};

        // Directed table: idle tick, drop on an empty table, field extremes, the ignored
        // command, a full table of equal deadlines, the full report and a sixteen-event tick.
        directed_rows.push_back(make_row(CMD_TICK, '0, '0, 1'b1,
            make_outcome(KIND_IDLE, STATUS_OK, '0, '0, 48'd1)));
        directed_rows.push_back(make_row(CMD_DROP, '0, 16'hFFFF, 1'b1,
            make_outcome(KIND_DROP, STATUS_NOT_FOUND, 16'hFFFF, '0, 48'd1)));
        directed_rows.push_back(make_row(CMD_INSERT, '0, '0, 1'b1,
            make_outcome(KIND_INSERT, STATUS_OK, '0, 48'd1, 48'd1)));
        directed_rows.push_back(make_row(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
            make_outcome(KIND_INSERT, STATUS_OK, 16'hFFFF, 48'h1_0000_0000, 48'd1)));
        directed_rows.push_back(make_row(CMD_TICK, '0, '0, 1'b0, '0));
        directed_rows.push_back(make_row(CMD_DROP, '0, 16'hFFFF, 1'b1,
            make_outcome(KIND_DROP, STATUS_OK, 16'hFFFF, 48'h1_0000_0000, 48'd2)));
        directed_rows.push_back(make_row(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, '0));
        for (i = 0; i < TABLE_DEPTH; i++)
            directed_rows.push_back(make_row(CMD_INSERT, '0, 16'(i * 16'h1111), 1'b0, '0));
        directed_rows.push_back(make_row(CMD_INSERT, 32'hFFFF_FFFF, 16'hBEEF, 1'b1,
            make_outcome(KIND_INSERT, STATUS_FULL, 16'hBEEF, 48'h1_0000_0001, 48'd2)));
        directed_rows.push_back(make_row(CMD_TICK, '0, '0, 1'b0, '0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k])
            send_beat(directed_rows[k], 0);
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge i_clk);

        // Random phases; each ends with the sender holding off until all results are in.
        for (ph = 0; ph < 4; ph++) begin
            stall_pct = phase_recv_stall[ph];
            done = 0;
            while (done < RANDOM_PER_PHASE) begin
                row = random_row(((done / 40) % 2) == 0);
                send_beat(row, phase_send_idle[ph]);
                if (row.cmd != CMD_UNUSED)
                    done++;
            end
            i_in_valid <= 1'b0;
            while (awaited_results.size() != 0)
                @(posedge i_clk);
        end

        // Let any stray beat show up before the verdict.
        stall_pct = 0;
        repeat (64) @(posedge i_clk);
        leftover = awaited_results.size();

        $display("Covered %0d input beats (%0d ignored): %0d events fired, %0d idle ticks,",
                 beats_sent, ignored_count, fired_count, idle_count);
        $display("%0d inserts refused on a full table, %0d drops of absent tags; final tick %0d.",
                 full_count, missing_count, shadow_now);
        if (mismatch_count == 0 && unexpected_count == 0 && leftover == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d unexpected beats, %0d results never seen.",
                     mismatch_count, unexpected_count, leftover);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
